@@ sv/power_to_dbfs_converter_top_assert.svh @@
// ----------------------------------------------------------------------------
// power_to_dbfs_converter_top_assert.svh
// assertion macros for the power to dbfs converter
// ----------------------------------------------------------------------------
`ifndef POWER_TO_DBFS_CONVERTER_TOP_ASSERT_SVH
`define POWER_TO_DBFS_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define PDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdc_pkg
// shared types and constants of the power to dbfs converter
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int POWER_W       = 64;
    localparam int MANT_Q        = 30;        // mantissa fraction bits
    localparam int MANT_W        = 31;        // q30 mantissa in [1.0, 2.0)
    localparam int IP_W          = 6;         // integer part of log2
    localparam int DB_PER_OCT    = 30103;     // 10*log10(2) scaled by 1e4
    localparam int DB_PER_OCT_W  = 15;
    localparam int LEVEL_DIV     = 1000;
    localparam int Y_W           = 22;        // scaled level before /1000
    localparam int RECIP         = 2147483;   // floor(2^31 / 1000)
    localparam int RECIP_W       = 22;
    localparam int RECIP_SHIFT   = 31;
    localparam int Q_W           = 13;        // level magnitude
    localparam int LEVEL_W       = 12;
    localparam int LEVEL_MIN     = -2048;
    localparam int LEVEL_MAX     = 2047;

    typedef logic signed [LEVEL_W-1:0] t_level;

    typedef struct packed {
        logic              zero;
        logic [IP_W-1:0]   ip;
        logic [MANT_W-1:0] mant;
    } t_norm;

endpackage

@@ sv/pdc_norm.sv @@
// ----------------------------------------------------------------------------
// pdc_norm
// leading-one detect and normalisation of the power to a q30 mantissa
// ----------------------------------------------------------------------------
module pdc_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pdc_pkg::POWER_W-1:0]  i_power,
    output logic                         o_valid,
    input  logic                         i_ready,
    output pdc_pkg::t_norm               o_norm
);

    logic                              en1, en2, en3;
    logic                              r_v1, r_v2, r_v3;
    logic [pdc_pkg::POWER_W-1:0]       r_pwr1, r_pwr2;
    logic [7:0]                        r_nz1, n_nz;
    logic [7:0][2:0]                   r_pos1, n_pos;
    logic [pdc_pkg::IP_W-1:0]          r_ip2, n_ip;
    logic                              r_zero2, n_zero;
    logic [pdc_pkg::POWER_W-1:0]       n_shift;
    pdc_pkg::t_norm                    r_norm3, n_norm;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_norm  = r_norm3;

    // per byte: any bit set, and position of its top bit
    always_comb begin
        for (int g = 0; g < 8; g++) begin
            n_nz[g]  = |i_power[8*g +: 8];
            n_pos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (i_power[8*g + b]) begin
                    n_pos[g] = 3'(b);
                end
            end
        end
    end

    // highest non-empty byte gives the integer part
    always_comb begin
        n_ip = '0;
        for (int g = 0; g < 8; g++) begin
            if (r_nz1[g]) begin
                n_ip = {3'(g), r_pos1[g]};
            end
        end
        n_zero = ~|r_nz1;
    end

    always_comb begin
        if (r_ip2 >= pdc_pkg::IP_W'(pdc_pkg::MANT_Q)) begin
            n_shift = r_pwr2 >> (r_ip2 - pdc_pkg::IP_W'(pdc_pkg::MANT_Q));
        end else begin
            n_shift = r_pwr2 << (pdc_pkg::IP_W'(pdc_pkg::MANT_Q) - r_ip2);
        end
        n_norm.zero = r_zero2;
        n_norm.ip   = r_ip2;
        n_norm.mant = n_shift[pdc_pkg::MANT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_pwr1 <= i_power;
            r_nz1  <= n_nz;
            r_pos1 <= n_pos;
        end
        if (en2 && r_v1) begin
            r_pwr2  <= r_pwr1;
            r_ip2   <= n_ip;
            r_zero2 <= n_zero;
        end
        if (en3 && r_v2) begin
            r_norm3 <= n_norm;
        end
    end

endmodule

@@ sv/pdc_sqr.sv @@
// ----------------------------------------------------------------------------
// pdc_sqr
// one squaring stage: yields one fraction bit of log2
// ----------------------------------------------------------------------------
module pdc_sqr #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pdc_pkg::t_norm        i_norm,
    input  logic [FRAC_BITS-1:0]  i_frac,
    output logic                  o_valid,
    input  logic                  i_ready,
    output pdc_pkg::t_norm        o_norm,
    output logic [FRAC_BITS-1:0]  o_frac
);

    logic                              en;
    logic                              r_v;
    logic [2*pdc_pkg::MANT_W-1:0]      n_sq;
    logic [pdc_pkg::MANT_W:0]          n_t;
    logic                              n_bit;
    pdc_pkg::t_norm                    r_norm, n_norm;
    logic [FRAC_BITS-1:0]              r_frac;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_norm  = r_norm;
    assign o_frac  = r_frac;

    // square, back to q30; a value of 2.0 or more halves and sets the bit
    always_comb begin
        n_sq  = i_norm.mant * i_norm.mant;
        n_t   = n_sq[2*pdc_pkg::MANT_W-1:pdc_pkg::MANT_Q];
        n_bit = n_t[pdc_pkg::MANT_W];
        n_norm.zero = i_norm.zero;
        n_norm.ip   = i_norm.ip;
        n_norm.mant = n_bit ? n_t[pdc_pkg::MANT_W:1] : n_t[pdc_pkg::MANT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_norm <= n_norm;
            r_frac <= {i_frac[FRAC_BITS-2:0], n_bit};
        end
    end

endmodule

@@ sv/pdc_scale.sv @@
// ----------------------------------------------------------------------------
// pdc_scale
// full-scale offset, scaling to tenths of a db, rounding and saturation
// ----------------------------------------------------------------------------
module pdc_scale #(
    parameter int FRAC_BITS       = 16,
    parameter int FULL_SCALE_LOG2 = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pdc_pkg::t_norm        i_norm,
    input  logic [FRAC_BITS-1:0]  i_frac,
    output logic                  o_valid,
    input  logic                  i_ready,
    output pdc_pkg::t_level       o_level_tenths,
    output logic                  o_zero_power
);

    localparam int LG_W   = pdc_pkg::IP_W + FRAC_BITS;
    localparam int PROD_W = LG_W + pdc_pkg::DB_PER_OCT_W;
    localparam int X_W    = PROD_W + 1;
    localparam int P_W    = pdc_pkg::Y_W + pdc_pkg::RECIP_W;
    localparam logic [LG_W-1:0] FS  = LG_W'(FULL_SCALE_LOG2) << FRAC_BITS;
    localparam logic [X_W-1:0]  RND = X_W'(pdc_pkg::LEVEL_DIV) << (FRAC_BITS - 1);

    logic [5:0]                    en;
    logic [5:0]                    r_v;
    logic [4:0]                    r_neg;
    logic [5:0]                    r_zero;
    logic [LG_W-1:0]               n_lg, n_mag, r_mag0;
    logic                          n_neg;
    logic [PROD_W-1:0]             n_prod, r_prod1;
    logic [X_W-1:0]                n_x;
    logic [pdc_pkg::Y_W-1:0]       n_y, r_y2, r_y3, n_r;
    logic [P_W-1:0]                n_p;
    logic [pdc_pkg::Q_W-1:0]       n_q0, r_q3, n_q, r_q4;
    logic signed [pdc_pkg::Q_W:0]  n_sgn;
    pdc_pkg::t_level               n_lvl, r_lvl5;

    always_comb begin
        en[5] = !r_v[5] || i_ready;
        for (int k = 4; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready        = en[0];
    assign o_valid        = r_v[5];
    assign o_level_tenths = r_lvl5;
    assign o_zero_power   = r_zero[5];

    // offset from full scale
    always_comb begin
        n_lg  = {i_norm.ip, i_frac};
        n_neg = n_lg < FS;
        n_mag = n_neg ? (FS - n_lg) : (n_lg - FS);
    end

    assign n_prod = PROD_W'(r_mag0) * PROD_W'(pdc_pkg::DB_PER_OCT);

    // round half up, then drop the fraction bits
    assign n_x = X_W'(r_prod1) + RND;
    assign n_y = n_x[X_W-1:FRAC_BITS];

    // divide by 1000 with a reciprocal, low by at most one
    assign n_p  = P_W'(r_y2) * P_W'(pdc_pkg::RECIP);
    assign n_q0 = n_p[pdc_pkg::RECIP_SHIFT +: pdc_pkg::Q_W];

    always_comb begin
        n_r = r_y3 - pdc_pkg::Y_W'(pdc_pkg::Y_W'(r_q3) * pdc_pkg::Y_W'(pdc_pkg::LEVEL_DIV));
        n_q = (n_r >= pdc_pkg::Y_W'(pdc_pkg::LEVEL_DIV)) ? pdc_pkg::Q_W'(r_q3 + 1'b1) : r_q3;
    end

    // sign, saturation, zero power reads as level 0
    always_comb begin
        n_sgn = r_neg[4] ? -$signed({1'b0, r_q4}) : $signed({1'b0, r_q4});
        if (r_zero[4]) begin
            n_lvl = '0;
        end else if (n_sgn < pdc_pkg::LEVEL_MIN) begin
            n_lvl = pdc_pkg::LEVEL_W'(pdc_pkg::LEVEL_MIN);
        end else if (n_sgn > pdc_pkg::LEVEL_MAX) begin
            n_lvl = pdc_pkg::LEVEL_W'(pdc_pkg::LEVEL_MAX);
        end else begin
            n_lvl = n_sgn[pdc_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_valid) begin
            r_mag0    <= n_mag;
            r_neg[0]  <= n_neg;
            r_zero[0] <= i_norm.zero;
        end
        for (int k = 1; k < 6; k++) begin
            if (en[k] && r_v[k-1]) r_zero[k] <= r_zero[k-1];
        end
        for (int k = 1; k < 5; k++) begin
            if (en[k] && r_v[k-1]) r_neg[k] <= r_neg[k-1];
        end
        if (en[1] && r_v[0]) r_prod1 <= n_prod;
        if (en[2] && r_v[1]) r_y2 <= n_y;
        if (en[3] && r_v[2]) begin
            r_y3 <= r_y2;
            r_q3 <= n_q0;
        end
        if (en[4] && r_v[3]) r_q4 <= n_q;
        if (en[5] && r_v[4]) r_lvl5 <= n_lvl;
    end

endmodule

@@ sv/power_to_dbfs_converter_top.sv @@
// ----------------------------------------------------------------------------
// power_to_dbfs_converter_top
// mean-square power to level in tenths of a db relative to full scale
// ----------------------------------------------------------------------------
// usage
//   input channel : i_valid / o_ready, one 64-bit unsigned power per item
//   output channel: o_valid / i_ready, o_level_tenths (signed, 12 bits)
//                   and o_zero_power, one result item per input item
//   pipeline      : the normaliser, the squaring chain and then the scaler,
//                   each made of registered stages
//   throughput    : one item per cycle unless stalled; each fraction bit
//                   of log2 has its own stage and 31 x 31 squaring multiplier
//   every stage holds its own valid bit and takes a new item when it is
//   empty or its successor moves, so bubbles close up while the receiver
//   stalls; o_ready only drops once every stage holds an item
//   reset clears all valid bits; nothing else needs clearing
//   a power of zero gives o_zero_power high and a level of 0
// ----------------------------------------------------------------------------
`include "power_to_dbfs_converter_top_assert.svh"

module power_to_dbfs_converter_top #(
    parameter int FRAC_BITS       = 16,
    parameter int FULL_SCALE_LOG2 = 30
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pdc_pkg::POWER_W-1:0]  i_power,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [pdc_pkg::LEVEL_W-1:0] o_level_tenths,
    output logic                         o_zero_power
);

    // links between the normaliser, the squaring chain and the scaler
    logic                 w_valid [FRAC_BITS+1];
    logic                 w_ready [FRAC_BITS+1];
    pdc_pkg::t_norm       w_norm  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] w_frac  [FRAC_BITS+1];

    assign w_frac[0] = '0;

    // leading-one detect and shift to a q30 mantissa, three stages
    pdc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_power (i_power),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_norm  (w_norm[0])
    );

    // one stage per fraction bit, msb first
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sqr
        pdc_sqr #(
            .FRAC_BITS (FRAC_BITS)
        ) u_sqr (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_norm  (w_norm[k]),
            .i_frac  (w_frac[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_norm  (w_norm[k+1]),
            .o_frac  (w_frac[k+1])
        );
    end

    // offset, scaling, rounding and saturation, six stages
    pdc_scale #(
        .FRAC_BITS       (FRAC_BITS),
        .FULL_SCALE_LOG2 (FULL_SCALE_LOG2)
    ) u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid[FRAC_BITS]),
        .o_ready        (w_ready[FRAC_BITS]),
        .i_norm         (w_norm[FRAC_BITS]),
        .i_frac         (w_frac[FRAC_BITS]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_level_tenths (o_level_tenths),
        .o_zero_power   (o_zero_power)
    );

    // a zero-power item always reads as level 0
    `PDC_ASSERT_SAME(a_zero_level, o_valid && o_zero_power, o_level_tenths == '0,
        "zero power item with non-zero level")

    // with the output stage empty the whole chain must be able to take an item
    `PDC_ASSERT_SAME(a_ready_chain, !o_valid, o_ready,
        "input stalled while the output stage is empty")

    // a non-zero power leaves the normaliser with its top mantissa bit set
    `PDC_ASSERT_SAME(a_norm_msb, w_valid[0] && !w_norm[0].zero,
        w_norm[0].mant[pdc_pkg::MANT_W-1], "mantissa not normalised")

    // and a squaring stage keeps it normalised
    `PDC_ASSERT_NEXT(a_sqr_msb, w_valid[0] && w_ready[0] && !w_norm[0].zero,
        w_norm[1].mant[pdc_pkg::MANT_W-1], "mantissa lost normalisation")

endmodule

@@ sim/tb_power_to_dbfs_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_to_dbfs_converter_top
// self-checking bench for the power to dbfs converter
// ----------------------------------------------------------------------------
// a table of directed powers (zero, one, full scale, the largest values and
// bit patterns) is walked first, then about 800 random powers in three
// traffic phases. every accepted power without its own answer is run
// through a local bit-true model of the log2 and dB scaling, and each
// result item is matched in order against the oldest prediction
// ----------------------------------------------------------------------------
module tb_power_to_dbfs_converter_top;

    localparam int FRAC_BITS       = 16;
    localparam int FULL_SCALE_LOG2 = 30;
    localparam int MANT_FRAC       = 30;        // q30 mantissa
    localparam int TENTHS_PER_OCT  = 30103;
    localparam int TENTHS_SCALE    = 1000;
    localparam int PIPE_LATENCY    = 3 + FRAC_BITS + 6;
    localparam int RANDOM_ITEMS    = 800;
    localparam int STALL_LIMIT     = 2000;      // cycles with no handshake at all

    // one entry of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [pdc_pkg::POWER_W-1:0] power;
        logic                        typed;
        pdc_pkg::t_level             level;
        logic                        zero;
    } t_vec;

    typedef struct packed {
        pdc_pkg::t_level level;
        logic            zero;
    } t_dbfs;

    localparam int N_DIRECTED = 19;
    localparam t_vec DIRECTED [N_DIRECTED] = '{
        // zero power: flag set, level reads 0
        '{64'd0,                    1'b1, 12'sd0,    1'b1},
        // smallest non-zero power, bottom of the range
        '{64'd1,                    1'b1, -12'sd903, 1'b0},
        // exactly full scale
        '{64'd1 << 30,              1'b1, 12'sd0,    1'b0},
        // top power of two, 33 octaves above full scale
        '{64'd1 << 63,              1'b1, 12'sd993,  1'b0},
        '{64'd2,                    1'b0, 12'sd0,    1'b0},
        '{64'd3,                    1'b0, 12'sd0,    1'b0},
        '{(64'd1 << 30) - 64'd1,    1'b0, 12'sd0,    1'b0},
        '{(64'd1 << 30) + 64'd1,    1'b0, 12'sd0,    1'b0},
        // all ones, top of the range
        '{64'hFFFF_FFFF_FFFF_FFFF,  1'b0, 12'sd0,    1'b0},
        '{64'h7FFF_FFFF_FFFF_FFFF,  1'b0, 12'sd0,    1'b0},
        '{64'h8000_0000_0000_0001,  1'b0, 12'sd0,    1'b0},
        '{64'h5555_5555_5555_5555,  1'b0, 12'sd0,    1'b0},
        '{64'hAAAA_AAAA_AAAA_AAAA,  1'b0, 12'sd0,    1'b0},
        '{64'd1 << 62,              1'b0, 12'sd0,    1'b0},
        '{64'd1 << 31,              1'b0, 12'sd0,    1'b0},
        '{64'd1 << 29,              1'b0, 12'sd0,    1'b0},
        '{64'd1 << 32,              1'b0, 12'sd0,    1'b0},
        '{64'd1000,                 1'b0, 12'sd0,    1'b0},
        '{64'd12345678,             1'b0, 12'sd0,    1'b0}
    };

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic [pdc_pkg::POWER_W-1:0]  i_power        = '0;
    logic                         i_ready        = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    pdc_pkg::t_level              o_level_tenths;
    logic                         o_zero_power;

    t_dbfs       level_queue [$];
    int unsigned mismatch_count  = 0;
    int unsigned sender_idle_pct = 28;
    int unsigned recv_idle_pct   = 55;
    int unsigned quiet_cycles    = 0;

    power_to_dbfs_converter_top #(
        .FRAC_BITS       (FRAC_BITS),
        .FULL_SCALE_LOG2 (FULL_SCALE_LOG2)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_power        (i_power),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_level_tenths (o_level_tenths),
        .o_zero_power   (o_zero_power)
    );

    always #4 i_clk = ~i_clk;

    // bit-true level of one power: leading-one detect, q30 mantissa,
    // fraction bits by repeated squaring, then scale and round half away
    function automatic t_dbfs dbfs_of_power(input logic [pdc_pkg::POWER_W-1:0] p);
        t_dbfs       r;
        int unsigned ip;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] lg;
        logic [63:0] fs;
        logic [63:0] mag;
        logic [63:0] divisor;
        logic [63:0] q;
        logic        neg;
        r.zero  = 1'b0;
        r.level = '0;
        if (p == '0) begin
            r.zero = 1'b1;
            return r;
        end
        ip = 0;
        for (int b = 0; b < pdc_pkg::POWER_W; b++)
            if (p[b]) ip = b;
        if (ip >= MANT_FRAC) m = p >> (ip - MANT_FRAC);
        else                 m = p << (MANT_FRAC - ip);
        frac = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            m    = (m * m) >> MANT_FRAC;
            frac = frac << 1;
            if (m >= (64'd1 << (MANT_FRAC + 1))) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        lg = (64'(ip) << FRAC_BITS) | frac;
        fs = 64'(FULL_SCALE_LOG2) << FRAC_BITS;
        neg = (lg < fs);
        mag = neg ? fs - lg : lg - fs;
        divisor = (64'd1 << FRAC_BITS) * TENTHS_SCALE;
        q = (mag * TENTHS_PER_OCT + divisor / 2) / divisor;
        // saturate to the 12-bit range, only reachable off the defaults
        if (neg) r.level = (q > 64'(-pdc_pkg::LEVEL_MIN)) ?
                           pdc_pkg::t_level'(pdc_pkg::LEVEL_MIN) : pdc_pkg::t_level'(-q);
        else     r.level = (q > 64'(pdc_pkg::LEVEL_MAX)) ?
                           pdc_pkg::t_level'(pdc_pkg::LEVEL_MAX) : pdc_pkg::t_level'(q);
        return r;
    endfunction

    // presents one power, idling first at the current sender rate, and
    // records its expected result once the handshake completes
    task automatic send_power(input logic [pdc_pkg::POWER_W-1:0] p, input logic typed,
                              input t_dbfs typed_exp);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_power <= p;
        do @(posedge i_clk); while (!o_ready);
        level_queue.push_back(typed ? typed_exp : dbfs_of_power(p));
    endtask

    // holds the input quiet until every outstanding result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (level_queue.size() != 0) @(posedge i_clk);
    endtask

    // random power with a spread of magnitudes so every octave is hit
    function automatic logic [pdc_pkg::POWER_W-1:0] random_power();
        logic [pdc_pkg::POWER_W-1:0] full;
        int unsigned                 k;
        int unsigned                 pick;
        full = {$urandom, $urandom};
        k    = $urandom_range(pdc_pkg::POWER_W - 1);
        pick = $urandom_range(99);
        if (pick < 35) return full;
        if (pick < 75) return (64'd1 << k) | (full & ((64'd1 << k) - 64'd1));
        if (pick < 87) begin
            case ($urandom_range(2))
                0:       return 64'd1 << k;
                1:       return (64'd1 << k) - 64'd1;
                default: return (64'd1 << k) + 64'd1;
            endcase
        end
        if (pick < 93) return '0;
        return 64'($urandom_range(1000, 1));
    endfunction

    // receiver side: ready toggles at the phase rate
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else          i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker, in order against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_dbfs want;
        if (i_rst_n && o_valid && i_ready) begin
            if (level_queue.size() == 0) begin
                $display("%0t: unexpected result level=%0d zero=%0b",
                         $time, o_level_tenths, o_zero_power);
                mismatch_count++;
            end else begin
                want = level_queue.pop_front();
                if (o_level_tenths !== want.level) begin
                    $display("%0t: level_tenths expected %0d actual %0d",
                             $time, want.level, o_level_tenths);
                    mismatch_count++;
                end
                if (o_zero_power !== want.zero) begin
                    $display("%0t: zero_power expected %0b actual %0b",
                             $time, want.zero, o_zero_power);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_dbfs typed_exp;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, under the first idling mix
        for (int n = 0; n < N_DIRECTED; n++) begin
            typed_exp.level = DIRECTED[n].level;
            typed_exp.zero  = DIRECTED[n].zero;
            send_power(DIRECTED[n].power, DIRECTED[n].typed, typed_exp);
        end
        // sender waits for every outstanding result at least once
        drain_results();

        // random powers: sender light / receiver heavy, swapped, then flat out
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 28; recv_idle_pct = 55; end
                1: begin sender_idle_pct = 55; recv_idle_pct = 28; end
                default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_power(random_power(), 1'b0, typed_exp);
            drain_results();
        end

        // let any stray item surface after the last expected one
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        if (mismatch_count == 0 && level_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ power_to_dbfs_converter_top.f @@
+incdir+sv
sv/pdc_pkg.sv
sv/pdc_norm.sv
sv/pdc_sqr.sv
sv/pdc_scale.sv
sv/power_to_dbfs_converter_top.sv
sim/tb_power_to_dbfs_converter_top.sv
